### rtl/core/single_wire_humidity_sensor_reader_top_macros.svh
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader: assertion macros
// Concurrent check helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SWHR_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swhr check failed");
// next-cycle implication
`define SWHR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swhr check failed");
`else
`define SWHR_ASSERT_IMPLY(lbl, ante, cons)
`define SWHR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/swhr_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader package
// Phase codes, register indexes, configuration and result types.
// ----------------------------------------------------------------------------
package swhr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_LOW      = 3'd1,
        PH_REL      = 3'd2,
        PH_ACK_LOW  = 3'd3,
        PH_ACK_HIGH = 3'd4,
        PH_BIT_HIGH = 3'd5,
        PH_BIT_LOW  = 3'd6,
        PH_DELAY    = 3'd7
    } phase_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 2'd3;

    localparam logic [15:0] START_LOW_RST    = 16'd20000;
    localparam logic [7:0]  RELEASE_RST      = 8'd30;
    localparam logic [7:0]  TIMEOUT_RST      = 8'd100;
    localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd40;

    localparam logic [5:0] FRAME_BITS = 6'd40;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  timeout_ticks;
        logic [7:0]  sample_delay_ticks;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       read_failed;
        logic       checksum_ok;
        logic [7:0] humidity_int;
        logic [7:0] humidity_frac;
        logic [7:0] temp_int;
        logic [7:0] temp_frac;
        logic       below_zero;
    } result_t;

endpackage

### rtl/core/single_wire_humidity_sensor_reader_top.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader, top level
// Tick-driven single-wire sensor reader with a result register and a write port.
// ----------------------------------------------------------------------------
// Usage: present one item per microsecond tick on the input channel
// (start_request, line_level). Each transfer advances the read sequence by
// one tick and yields exactly one result on the output channel: line drive,
// busy, done/failed/checksum flags, the held reading and the sign flag, all
// reflecting the state after that tick.
// Latency: the result is valid in the cycle after the input transfer.
// Throughput: one item per clock; the sequencer updates its state on each
// transfer and one result register separates the two channels.
// When the receiver stalls, the result register holds and in_ready drops
// until the pending result is transferred; a result draining in the same
// cycle lets the next item in.
// Reset returns the sequencer to idle, clears the held reading and the sign
// flag, loads the default timing registers and empties the result register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods only.
// ----------------------------------------------------------------------------
`include "single_wire_humidity_sensor_reader_top_macros.svh"

module single_wire_humidity_sensor_reader_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_request,
    input  logic        line_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drive_low,
    output logic        busy_res,
    output logic        done_res,
    output logic        read_failed,
    output logic        checksum_ok,
    output logic [7:0]  humidity_int,
    output logic [7:0]  humidity_frac,
    output logic [7:0]  temp_int,
    output logic [7:0]  temp_frac,
    output logic        below_zero
);

    swhr_pkg::cfg_t    cfg_reg;
    swhr_pkg::result_t res_next;
    swhr_pkg::result_t res;
    logic              tick_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks    <= swhr_pkg::START_LOW_RST;
            cfg_reg.release_ticks      <= swhr_pkg::RELEASE_RST;
            cfg_reg.timeout_ticks      <= swhr_pkg::TIMEOUT_RST;
            cfg_reg.sample_delay_ticks <= swhr_pkg::SAMPLE_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swhr_pkg::REG_START_LOW:    cfg_reg.start_low_ticks    <= cfg_data;
                swhr_pkg::REG_RELEASE:      cfg_reg.release_ticks      <= cfg_data[7:0];
                swhr_pkg::REG_TIMEOUT:      cfg_reg.timeout_ticks      <= cfg_data[7:0];
                swhr_pkg::REG_SAMPLE_DELAY: cfg_reg.sample_delay_ticks <= cfg_data[7:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // advance one tick per input transfer
    assign tick_en = in_valid && in_ready;

    swhr_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .tick_en       (tick_en),
        .start_request (start_request),
        .line_level    (line_level),
        .res_next      (res_next)
    );

    swhr_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .res_next  (res_next),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign drive_low     = res.drive_low;
    assign busy_res      = res.busy_res;
    assign done_res      = res.done_res;
    assign read_failed   = res.read_failed;
    assign checksum_ok   = res.checksum_ok;
    assign humidity_int  = res.humidity_int;
    assign humidity_frac = res.humidity_frac;
    assign temp_int      = res.temp_int;
    assign temp_frac     = res.temp_frac;
    assign below_zero    = res.below_zero;

    `SWHR_ASSERT_NEXT(a_transfer_gives_result, tick_en, out_valid)
    `SWHR_ASSERT_IMPLY(a_done_ends_busy, out_valid && done_res, !busy_res)
    `SWHR_ASSERT_IMPLY(a_fail_only_with_done, out_valid && read_failed,
                       done_res && !checksum_ok)
    `SWHR_ASSERT_IMPLY(a_drive_only_busy, out_valid && drive_low, busy_res)

endmodule

### rtl/core/swhr_ctrl.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader: protocol sequencer
// Holds the read state and advances it by one tick per transfer.
// ----------------------------------------------------------------------------
module swhr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  swhr_pkg::cfg_t   cfg,
    input  logic             tick_en,
    input  logic             start_request,
    input  logic             line_level,
    output swhr_pkg::result_t res_next
);

    swhr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [5:0]  bit_reg, bit_next;
    logic [39:0] frame_reg, frame_next;
    logic [31:0] held_reg, held_next;
    logic        sign_reg, sign_next;

    logic [16:0] tick_inc;
    logic [39:0] frame_shifted;
    logic [5:0]  bit_inc;
    logic [7:0]  byte_sum;
    logic        done, failed, ok;
    logic        line_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= swhr_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            frame_reg <= '0;
            held_reg  <= '0;
            sign_reg  <= 1'b0;
        end
        else if (tick_en)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            frame_reg <= frame_next;
            held_reg  <= held_next;
            sign_reg  <= sign_next;
        end
    end

    assign tick_inc      = {1'b0, tick_reg} + 17'd1;
    assign frame_shifted = {frame_reg[38:0], line_level};
    assign bit_inc       = bit_reg + 6'd1;
    assign byte_sum      = frame_shifted[39:32] + frame_shifted[31:24]
                         + frame_shifted[23:16] + frame_shifted[15:8];

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        frame_next = frame_reg;
        held_next  = held_reg;
        sign_next  = sign_reg;
        done       = 1'b0;
        failed     = 1'b0;
        ok         = 1'b0;
        line_match = 1'b0;

        case (phase_reg)
            swhr_pkg::PH_IDLE:
            begin
                if (start_request)
                begin
                    phase_next = swhr_pkg::PH_LOW;
                    tick_next  = '0;
                end
            end
            swhr_pkg::PH_LOW:
            begin
                tick_next = tick_inc[15:0];
                if (tick_inc >= {1'b0, cfg.start_low_ticks})
                begin
                    phase_next = swhr_pkg::PH_REL;
                    tick_next  = '0;
                end
            end
            swhr_pkg::PH_REL:
            begin
                tick_next = tick_inc[15:0];
                if (tick_inc >= {9'd0, cfg.release_ticks})
                begin
                    phase_next = swhr_pkg::PH_ACK_LOW;
                    tick_next  = '0;
                end
            end
            swhr_pkg::PH_ACK_LOW, swhr_pkg::PH_ACK_HIGH:
            begin
                line_match = (line_level == (phase_reg == swhr_pkg::PH_ACK_HIGH));
                if (line_match)
                begin
                    phase_next = (phase_reg == swhr_pkg::PH_ACK_LOW)
                               ? swhr_pkg::PH_ACK_HIGH : swhr_pkg::PH_BIT_HIGH;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc[15:0];
                    if (tick_inc >= {9'd0, cfg.timeout_ticks})
                    begin
                        // sensor never answered: abort
                        phase_next = swhr_pkg::PH_IDLE;
                        tick_next  = '0;
                        done       = 1'b1;
                        failed     = 1'b1;
                    end
                end
            end
            swhr_pkg::PH_BIT_HIGH, swhr_pkg::PH_BIT_LOW:
            begin
                line_match = (line_level == (phase_reg == swhr_pkg::PH_BIT_LOW));
                tick_next  = tick_inc[15:0];
                // a timeout here just advances as if the edge came
                if (line_match || (tick_inc >= {9'd0, cfg.timeout_ticks}))
                begin
                    phase_next = (phase_reg == swhr_pkg::PH_BIT_HIGH)
                               ? swhr_pkg::PH_BIT_LOW : swhr_pkg::PH_DELAY;
                    tick_next  = '0;
                end
            end
            swhr_pkg::PH_DELAY:
            begin
                tick_next = tick_inc[15:0];
                if (tick_inc >= {9'd0, cfg.sample_delay_ticks})
                begin
                    tick_next  = '0;
                    frame_next = frame_shifted;
                    bit_next   = bit_inc;
                    if (bit_inc >= swhr_pkg::FRAME_BITS)
                    begin
                        if (byte_sum == frame_shifted[7:0])
                        begin
                            held_next = frame_shifted[39:8];
                            ok        = 1'b1;
                        end
                        sign_next  = frame_shifted[31];
                        done       = 1'b1;
                        phase_next = swhr_pkg::PH_IDLE;
                        bit_next   = '0;
                    end
                    else
                    begin
                        phase_next = swhr_pkg::PH_BIT_HIGH;
                    end
                end
            end
            default:
            begin
                phase_next = swhr_pkg::PH_IDLE;
            end
        endcase

        // clear the frame on a fresh start
        if ((phase_next == swhr_pkg::PH_LOW) && (tick_next == '0))
        begin
            bit_next   = '0;
            frame_next = '0;
        end
    end

    always_comb
    begin
        res_next.drive_low     = (phase_next == swhr_pkg::PH_LOW);
        res_next.busy_res      = (phase_next != swhr_pkg::PH_IDLE);
        res_next.done_res      = done;
        res_next.read_failed   = failed;
        res_next.checksum_ok   = ok;
        res_next.humidity_int  = held_next[31:24];
        res_next.humidity_frac = held_next[23:16];
        res_next.temp_int      = held_next[15:8];
        res_next.temp_frac     = held_next[7:0];
        res_next.below_zero    = sign_next;
    end

endmodule

### rtl/core/swhr_out_stage.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader: result register
// Holds one result until transferred; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module swhr_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swhr_pkg::result_t res_next,
    output logic              out_valid,
    input  logic              out_ready,
    output swhr_pkg::result_t res
);

    logic              valid_reg;
    swhr_pkg::result_t res_reg;
    logic              load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

### tb/swhr_result_checker.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader: result checker
// Mirrors the timing registers from the write port, runs a tick-level model of
// the reader for every input transfer and compares each output transfer,
// field by field, with the oldest predicted reading.
// ----------------------------------------------------------------------------
module swhr_result_checker
    import swhr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        start_request,
    input  logic        line_level,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        drive_low,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic        read_failed,
    input  logic        checksum_ok,
    input  logic [7:0]  humidity_int,
    input  logic [7:0]  humidity_frac,
    input  logic [7:0]  temp_int,
    input  logic [7:0]  temp_frac,
    input  logic        below_zero,
    output int          fail_count,
    output int          outstanding,
    output logic        reader_busy
);

    // mirrored timing registers
    logic [15:0] low_r;
    logic [7:0]  rel_r;
    logic [7:0]  tmo_r;
    logic [7:0]  dly_r;

    // model state
    phase_t      rd_phase;
    logic [15:0] ticks;
    logic [5:0]  bits;
    logic [39:0] frame;
    logic [31:0] held;
    logic        sign;

    result_t     expected_readings[$];
    result_t     predicted;
    result_t     arrived;
    int          mismatches;

    task automatic advance_reader_tick(input logic start, input logic line,
                                       output result_t r);
        logic       done;
        logic       failed;
        logic       ok;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] sum;
        done   = 1'b0;
        failed = 1'b0;
        ok     = 1'b0;
        case (rd_phase)
            PH_IDLE:
            begin
                if (start)
                begin
                    rd_phase = PH_LOW;
                    ticks    = '0;
                end
            end
            PH_LOW:
            begin
                ticks = ticks + 16'd1;
                if (ticks >= low_r)
                begin
                    rd_phase = PH_REL;
                    ticks    = '0;
                end
            end
            PH_REL:
            begin
                ticks = ticks + 16'd1;
                if (ticks >= {8'd0, rel_r})
                begin
                    rd_phase = PH_ACK_LOW;
                    ticks    = '0;
                end
            end
            PH_ACK_LOW, PH_ACK_HIGH:
            begin
                if (line == (rd_phase == PH_ACK_HIGH))
                begin
                    rd_phase = (rd_phase == PH_ACK_LOW) ? PH_ACK_HIGH : PH_BIT_HIGH;
                    ticks    = '0;
                end
                else
                begin
                    ticks = ticks + 16'd1;
                    if (ticks >= {8'd0, tmo_r})
                    begin
                        rd_phase = PH_IDLE;
                        ticks    = '0;
                        done     = 1'b1;
                        failed   = 1'b1;
                    end
                end
            end
            PH_BIT_HIGH, PH_BIT_LOW:
            begin
                // a timeout here just moves the bit along
                ticks = ticks + 16'd1;
                if (line == (rd_phase == PH_BIT_LOW) || ticks >= {8'd0, tmo_r})
                begin
                    rd_phase = (rd_phase == PH_BIT_HIGH) ? PH_BIT_LOW : PH_DELAY;
                    ticks    = '0;
                end
            end
            default:
            begin
                ticks = ticks + 16'd1;
                if (ticks >= {8'd0, dly_r})
                begin
                    ticks = '0;
                    frame = {frame[38:0], line};
                    bits  = bits + 6'd1;
                    if (bits >= FRAME_BITS)
                    begin
                        b0  = frame[39:32];
                        b1  = frame[31:24];
                        b2  = frame[23:16];
                        b3  = frame[15:8];
                        b4  = frame[7:0];
                        sum = b0 + b1 + b2 + b3;
                        if (sum == b4)
                        begin
                            held = {b0, b1, b2, b3};
                            ok   = 1'b1;
                        end
                        sign     = b1[7];
                        done     = 1'b1;
                        rd_phase = PH_IDLE;
                        bits     = '0;
                    end
                    else
                    begin
                        rd_phase = PH_BIT_HIGH;
                    end
                end
            end
        endcase

        // clear the frame on a fresh start
        if (rd_phase == PH_LOW && ticks == 16'd0)
        begin
            bits  = '0;
            frame = '0;
        end

        r.drive_low     = (rd_phase == PH_LOW);
        r.busy_res      = (rd_phase != PH_IDLE);
        r.done_res      = done;
        r.read_failed   = failed;
        r.checksum_ok   = ok;
        r.humidity_int  = held[31:24];
        r.humidity_frac = held[23:16];
        r.temp_int      = held[15:8];
        r.temp_frac     = held[7:0];
        r.below_zero    = sign;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_r    = START_LOW_RST;
            rel_r    = RELEASE_RST;
            tmo_r    = TIMEOUT_RST;
            dly_r    = SAMPLE_DELAY_RST;
            rd_phase = PH_IDLE;
            ticks    = '0;
            bits     = '0;
            frame    = '0;
            held     = '0;
            sign     = 1'b0;
            expected_readings.delete();
            mismatches = 0;
            fail_count  <= 0;
            outstanding <= 0;
            reader_busy <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_LOW:    low_r = cfg_data;
                    REG_RELEASE:      rel_r = cfg_data[7:0];
                    REG_TIMEOUT:      tmo_r = cfg_data[7:0];
                    REG_SAMPLE_DELAY: dly_r = cfg_data[7:0];
                    default:          ;
                endcase
            end

            // retire the output transfer first: it can never belong to this edge's input
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result transfer with no reading pending");
                    mismatches++;
                end
                else
                begin
                    arrived = expected_readings.pop_front();
                    compare_field("drive_low", arrived.drive_low, drive_low);
                    compare_field("busy_res", arrived.busy_res, busy_res);
                    compare_field("done_res", arrived.done_res, done_res);
                    compare_field("read_failed", arrived.read_failed, read_failed);
                    compare_field("checksum_ok", arrived.checksum_ok, checksum_ok);
                    compare_field("humidity_int", arrived.humidity_int, humidity_int);
                    compare_field("humidity_frac", arrived.humidity_frac, humidity_frac);
                    compare_field("temp_int", arrived.temp_int, temp_int);
                    compare_field("temp_frac", arrived.temp_frac, temp_frac);
                    compare_field("below_zero", arrived.below_zero, below_zero);
                end
            end

            if (in_valid && in_ready)
            begin
                advance_reader_tick(start_request, line_level, predicted);
                expected_readings.push_back(predicted);
            end

            fail_count  <= mismatches;
            outstanding <= expected_readings.size();
            reader_busy <= (rd_phase != PH_IDLE);
        end
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader: testbench top
// Plays sensor waveforms tick by tick into the reader under a range of timing
// settings, with random idling on both channels and a long output hold-off;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import swhr_pkg::*;

    typedef enum int {
        RD_GOOD,
        RD_BAD_SUM,
        RD_NO_ACK_LOW,
        RD_NO_ACK_HIGH,
        RD_STRETCHED,
        RD_NOISE
    } read_kind_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        start_request = 1'b0;
    logic        line_level    = 1'b1;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        read_failed;
    logic        checksum_ok;
    logic [7:0]  humidity_int;
    logic [7:0]  humidity_frac;
    logic [7:0]  temp_int;
    logic [7:0]  temp_frac;
    logic        below_zero;

    int          fail_count;
    int          outstanding;
    logic        reader_busy;

    int          send_idle_pct = 17;
    int          recv_idle_pct = 86;
    int          hold_req      = 0;
    int          hold_ack      = 0;
    int          hold_left     = 0;
    int          ticks_sent    = 0;

    // timing currently loaded in the block
    int          cur_low = START_LOW_RST;
    int          cur_rel = RELEASE_RST;
    int          cur_tmo = TIMEOUT_RST;
    int          cur_dly = SAMPLE_DELAY_RST;

    single_wire_humidity_sensor_reader_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_request (start_request),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .read_failed   (read_failed),
        .checksum_ok   (checksum_ok),
        .humidity_int  (humidity_int),
        .humidity_frac (humidity_frac),
        .temp_int      (temp_int),
        .temp_frac     (temp_frac),
        .below_zero    (below_zero)
    );

    swhr_result_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_request (start_request),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .read_failed   (read_failed),
        .checksum_ok   (checksum_ok),
        .humidity_int  (humidity_int),
        .humidity_frac (humidity_frac),
        .temp_int      (temp_int),
        .temp_frac     (temp_frac),
        .below_zero    (below_zero),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .reader_busy   (reader_busy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic rbit();
        return $urandom_range(1) != 0;
    endfunction

    // start requests while busy must be ignored
    function automatic logic busy_start();
        return $urandom_range(3) == 0;
    endfunction

    // length of a level run that stays under the timeout, now and then right at its edge
    function automatic int run_below(input int lim);
        if ($urandom_range(7) == 0)
            return lim - 1;
        return $urandom_range((lim - 1 < 4) ? lim - 1 : 4);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_tick(input logic start, input logic line);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_request <= start;
        line_level    <= line;
        do
            @(posedge clk);
        while (!in_ready);
        ticks_sent++;
    endtask

    task automatic wait_for_results();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int s, input int r, input int t, input int d);
        in_valid <= 1'b0;
        wait_for_results();
        // junk in the upper byte of the narrow registers must be dropped
        write_reg(REG_START_LOW, 16'(s));
        write_reg(REG_RELEASE, {8'($urandom), 8'(r)});
        write_reg(REG_TIMEOUT, {8'($urandom), 8'(t)});
        write_reg(REG_SAMPLE_DELAY, {8'($urandom), 8'(d)});
        cfg_we  <= 1'b0;
        cur_low = s;
        cur_rel = r;
        cur_tmo = t;
        cur_dly = d;
    endtask

    // one read from start request to idle again, the sensor side shaped by kind
    task automatic run_read(input read_kind_t kind);
        int          lo;
        int          rl;
        int          to;
        int          dl;
        int          run;
        int          i;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [39:0] bits_out;
        lo = (cur_low == 0) ? 1 : cur_low;
        rl = (cur_rel == 0) ? 1 : cur_rel;
        to = (cur_tmo == 0) ? 1 : cur_tmo;
        dl = (cur_dly == 0) ? 1 : cur_dly;
        b0 = pick_byte();
        b1 = pick_byte();
        b2 = pick_byte();
        b3 = pick_byte();
        b4 = b0 + b1 + b2 + b3;
        if (kind == RD_BAD_SUM)
            b4 = b4 + 8'($urandom_range(1, 255));
        bits_out = {b0, b1, b2, b3, b4};

        send_tick(1'b1, rbit());
        repeat (lo + rl) send_tick(busy_start(), rbit());
        if (kind == RD_NO_ACK_LOW)
        begin
            repeat (to) send_tick(busy_start(), 1'b1);
        end
        else
        begin
            repeat (run_below(to)) send_tick(busy_start(), 1'b1);
            send_tick(busy_start(), 1'b0);
            if (kind == RD_NO_ACK_HIGH)
            begin
                repeat (to) send_tick(busy_start(), 1'b0);
            end
            else
            begin
                repeat (run_below(to)) send_tick(busy_start(), 1'b0);
                send_tick(busy_start(), 1'b1);
                if (kind == RD_NOISE)
                begin
                    repeat (40 * (dl + 2)) send_tick(busy_start(), rbit());
                end
                else
                begin
                    for (i = 39; i >= 0; i--)
                    begin
                        run = (kind == RD_STRETCHED && $urandom_range(3) == 0)
                              ? to + $urandom_range(2) : run_below(to);
                        repeat (run) send_tick(busy_start(), 1'b1);
                        send_tick(busy_start(), 1'b0);
                        run = (kind == RD_STRETCHED && $urandom_range(3) == 0)
                              ? to + $urandom_range(2) : run_below(to);
                        repeat (run) send_tick(busy_start(), 1'b0);
                        send_tick(busy_start(), 1'b1);
                        repeat (dl - 1) send_tick(busy_start(), 1'b1);
                        // a start on the finishing tick must be ignored too
                        send_tick((i == 0) ? rbit() : busy_start(), bits_out[i]);
                    end
                end
            end
        end

        // pad until the reader is idle, then a few ignored ticks
        do
            send_tick(1'b0, rbit());
        while (reader_busy);
        repeat ($urandom_range(3)) send_tick(1'b0, rbit());
    endtask

    initial
    begin
        int m;
        int base;
        int draw;
        read_kind_t kind;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then a short drive-low with the reset release and timeout
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        in_valid <= 1'b0;
        wait_for_results();
        write_reg(REG_START_LOW, 16'd3);
        cfg_we  <= 1'b0;
        cur_low = 3;
        run_read(RD_NO_ACK_HIGH);

        // all-zero timing behaves like all ones
        apply_settings(0, 0, 0, 0);
        run_read(RD_GOOD);
        run_read(RD_NO_ACK_LOW);

        for (m = 0; m < 3; m++)
        begin
            send_idle_pct = (m == 0) ? 17 : (m == 1) ? 86 : 0;
            recv_idle_pct = (m == 0) ? 86 : (m == 1) ? 17 : 0;
            base = ticks_sent;
            while (ticks_sent - base < 150)
            begin
                apply_settings($urandom_range(6), $urandom_range(4),
                               ($urandom_range(4) == 0) ? $urandom_range(11, 40)
                                                        : $urandom_range(1, 10),
                               $urandom_range(6));
                // stall the output long enough for the input side to back up
                if (ticks_sent - base == 0)
                    hold_req <= hold_req + 1;
                draw = $urandom_range(99);
                if (draw < 55)
                    kind = RD_GOOD;
                else if (draw < 70)
                    kind = RD_BAD_SUM;
                else if (draw < 78)
                    kind = RD_NO_ACK_LOW;
                else if (draw < 86)
                    kind = RD_NO_ACK_HIGH;
                else if (draw < 94)
                    kind = RD_STRETCHED;
                else
                    kind = RD_NOISE;
                run_read(kind);
            end
        end

        // widest timeout
        apply_settings(2, 0, 255, 1);
        run_read(RD_NO_ACK_LOW);

        in_valid <= 1'b0;
        wait_for_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/swhr_pkg.sv
rtl/core/swhr_ctrl.sv
rtl/core/swhr_out_stage.sv
rtl/core/single_wire_humidity_sensor_reader_top.sv
tb/swhr_result_checker.sv
tb/testbench.sv
